>>> rtl/core/wlt_pkg.sv
package wlt_pkg;

    localparam int DEFAULT_ENTRIES = 16;

    localparam int FUNC_W  = 2;
    localparam int FILE_W  = 16;
    localparam int LINE_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int TASK_W  = 15;
    localparam int TIME_W  = 32;
    localparam int CAUSE_W = 3;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_START = 2'd0,
        FN_END   = 2'd1,
        FN_CLEAR = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    localparam logic [CAUSE_W-1:0] CAUSE_IRQ       = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_UNKNOWN   = 3'd5;
    localparam logic [CAUSE_W-1:0] CAUSE_RESERVED  = 3'd6;
    localparam logic [CAUSE_W-1:0] CAUSE_IRQ_ALIAS = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_UPDATE,
        ST_READ,
        ST_READ_DATA
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FILE_W-1:0]  file_id;
        logic [LINE_W-1:0]  line;
        logic [ADDR_W-1:0]  code_address;
        logic [TASK_W-1:0]  task_id;
        logic [TIME_W-1:0]  timestamp;
        logic [CAUSE_W-1:0] cause_code;
        logic               outermost;
        logic [IDX_W-1:0]   entry_index;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0]  entry_latency;
        logic [CAUSE_W-1:0] entry_cause;
        logic [FILE_W-1:0]  begin_file;
        logic [LINE_W-1:0]  begin_line;
        logic [ADDR_W-1:0]  begin_address;
        logic [TASK_W-1:0]  begin_task;
        logic [FILE_W-1:0]  finish_file;
        logic [LINE_W-1:0]  finish_line;
        logic [ADDR_W-1:0]  finish_address;
        logic [TASK_W-1:0]  finish_task;
        logic [COUNT_W-1:0] sample_count;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]  latency;
        logic [CAUSE_W-1:0] cause;
        logic [FILE_W-1:0]  from_file;
        logic [LINE_W-1:0]  from_line;
        logic [ADDR_W-1:0]  from_address;
        logic [TASK_W-1:0]  from_task;
        logic [FILE_W-1:0]  to_file;
        logic [LINE_W-1:0]  to_line;
        logic [ADDR_W-1:0]  to_address;
        logic [TASK_W-1:0]  to_task;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic do_start;
        logic do_clear;
        logic scan_init;
        logic scan_rd;
        logic update;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  active;
        logic  scan_last;
        logic  out_free;
    } t_status;

    function automatic logic [CAUSE_W-1:0] map_cause(input logic [CAUSE_W-1:0] c);
        logic [CAUSE_W-1:0] m;
        case (c)
            CAUSE_IRQ_ALIAS: m = CAUSE_IRQ;
            CAUSE_RESERVED:  m = CAUSE_UNKNOWN;
            default:         m = c;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/wlt_in_if.sv
interface wlt_in_if
    import wlt_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/wlt_out_if.sv
interface wlt_out_if
    import wlt_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/wlt_ram.sv
module wlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/wlt_ctrl.sv
module wlt_ctrl
    import wlt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_status.func)
                        FN_END: begin
                            if (i_status.active) begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_READ: n_state = ST_READ;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            ST_READ:   n_state = ST_READ_DATA;
            ST_READ_DATA: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.accept    = i_in_valid;
                o_cmd.do_start  = i_in_valid && (i_status.func == FN_START) && i_status.active;
                o_cmd.do_clear  = i_in_valid && (i_status.func == FN_CLEAR);
                o_cmd.scan_init = i_in_valid && (i_status.func == FN_END) && i_status.active;
            end
            ST_SCAN:      o_cmd.scan_rd = 1'b1;
            ST_UPDATE:    o_cmd.update = 1'b1;
            ST_READ_DATA: o_cmd.load_out = i_status.out_free;
            default: ;
        endcase
    end

endmodule

>>> rtl/core/wlt_datapath.sv
module wlt_datapath
    import wlt_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW = $bits(t_entry);

    logic               r_logging;
    t_in_item           r_item;
    logic [TIME_W-1:0]  r_pend_time;
    logic [CAUSE_W-1:0] r_pend_cause;
    logic [FILE_W-1:0]  r_pend_file;
    logic [LINE_W-1:0]  r_pend_line;
    logic [ADDR_W-1:0]  r_pend_address;
    logic [TASK_W-1:0]  r_pend_task;
    logic [COUNT_W-1:0] r_samples;
    logic [ENTRIES-1:0] r_valid;
    logic [AW-1:0]      r_cnt;
    logic               r_eval;
    logic [AW-1:0]      r_eval_idx;
    logic [TIME_W-1:0]  r_low;
    logic [AW-1:0]      r_pick;
    logic               r_found;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [AW-1:0]     item_addr;
    logic [AW-1:0]     raddr;
    logic [EW-1:0]     ram_q;
    t_entry            q_entry;
    t_entry            scan_ent;
    t_entry            rd_ent;
    t_entry            wr_ent;
    logic              idx_in_range;
    logic              match;
    logic [TIME_W-1:0] diff;
    logic              wr_en;

    assign item_addr    = AW'(r_item.entry_index);
    assign idx_in_range = int'(r_item.entry_index) < ENTRIES;
    assign raddr        = i_cmd.scan_rd ? r_cnt : item_addr;
    assign q_entry      = t_entry'(ram_q);
    assign scan_ent     = r_valid[r_eval_idx] ? q_entry : '0;
    assign rd_ent       = (idx_in_range && r_valid[item_addr]) ? q_entry : '0;
    assign match        = (scan_ent.to_line == r_item.line) && (scan_ent.to_file == r_item.file_id);
    assign diff         = r_item.timestamp - r_pend_time;
    assign wr_en        = i_cmd.update && (diff > r_low);

    always_comb begin
        wr_ent.latency      = diff;
        wr_ent.cause        = r_pend_cause;
        wr_ent.from_file    = r_pend_file;
        wr_ent.from_line    = r_pend_line;
        wr_ent.from_address = r_pend_address;
        wr_ent.from_task    = r_pend_task;
        wr_ent.to_file      = r_item.file_id;
        wr_ent.to_line      = r_item.line;
        wr_ent.to_address   = r_item.code_address;
        wr_ent.to_task      = r_item.task_id;
    end

    wlt_ram #(
        .WIDTH(EW),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_pick),
        .i_wdata(EW'(wr_ent)),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        o_status.func      = t_func'(i_in_data.func);
        o_status.active    = r_logging && i_in_data.outermost;
        o_status.scan_last = (r_cnt == AW'(ENTRIES - 1));
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logging      <= 1'b0;
            r_pend_time    <= '0;
            r_pend_cause   <= '0;
            r_pend_file    <= '0;
            r_pend_line    <= '0;
            r_pend_address <= '0;
            r_pend_task    <= '0;
            r_samples      <= '0;
            r_valid        <= '0;
            r_eval         <= 1'b0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_logging <= i_cfg_wdata;
            end
            if (i_cmd.do_start) begin
                r_pend_time    <= i_in_data.timestamp;
                r_pend_cause   <= map_cause(i_in_data.cause_code);
                r_pend_file    <= i_in_data.file_id;
                r_pend_line    <= i_in_data.line;
                r_pend_address <= i_in_data.code_address;
                r_pend_task    <= i_in_data.task_id;
            end
            if (i_cmd.do_clear) begin
                r_valid   <= '0;
                r_samples <= '0;
            end else if (i_cmd.update) begin
                r_samples <= r_samples + 1'b1;
                if (wr_en) begin
                    r_valid[r_pick] <= 1'b1;
                end
            end
            r_eval <= i_cmd.scan_rd;
            if (i_cmd.scan_init) begin
                r_found <= 1'b0;
            end else if (r_eval && !r_found && match) begin
                r_found <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.scan_init) begin
            r_cnt <= '0;
            r_low <= '1;
            r_pick <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end
            // first matching end point wins, else the lowest latency
            if (r_eval && !r_found) begin
                if (match || (r_low > scan_ent.latency)) begin
                    r_low  <= scan_ent.latency;
                    r_pick <= r_eval_idx;
                end
            end
        end
        r_eval_idx <= r_cnt;
        if (i_cmd.load_out) begin
            r_out.entry_latency  <= rd_ent.latency;
            r_out.entry_cause    <= rd_ent.cause;
            r_out.begin_file     <= rd_ent.from_file;
            r_out.begin_line     <= rd_ent.from_line;
            r_out.begin_address  <= rd_ent.from_address;
            r_out.begin_task     <= rd_ent.from_task;
            r_out.finish_file    <= rd_ent.to_file;
            r_out.finish_line    <= rd_ent.to_line;
            r_out.finish_address <= rd_ent.to_address;
            r_out.finish_task    <= rd_ent.to_task;
            r_out.sample_count   <= r_samples;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/worst_latency_tracker_core.sv
// Worst latency tracker. Start events (func 0) at the outermost nesting level latch the start
// point while logging is enabled; end events (func 1) compute the elapsed ticks and keep the
// ENTRIES worst ones, an entry per end point. Clear (func 2) empties the table and the sample
// counter; read (func 3) returns one entry plus the sample count as the only result transfer.
// Start, clear and gated events end in idle; a read waits in READ_DATA for a free output
// register; a recorded end event scans the entry memory through its single read port, one
// entry per cycle, then passes TAIL and UPDATE. Items go one at a time; a read result waits
// in an output register while the next item is taken. No clearing pass is needed after reset.
module worst_latency_tracker_core
    import wlt_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    wlt_in_if.sink           i_in,
    wlt_out_if.source        o_out
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    wlt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    wlt_datapath #(
        .ENTRIES(ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in.data),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_out_data (o_out.data)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!cmd.scan_rd && !cmd.update && !cmd.load_out))
        else $error("transfer accepted while an item is in progress");

    a_update_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |-> $past(cmd.scan_rd, 2))
        else $error("table update without a finished scan");

    a_scan_follows_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_init |=> cmd.scan_rd)
        else $error("scan did not start after init");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out.valid)
        else $error("read result not presented");
`endif

endmodule

>>> bench/tb_worst_latency_tracker_core.sv
`timescale 1ns / 1ps

module tb_worst_latency_tracker_core;
    import wlt_pkg::*;

    localparam int ENTRIES = DEFAULT_ENTRIES;
    localparam int SETTLE_CYCLES = ENTRIES + 8;
    localparam int POINTS = 24;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    wlt_in_if in_if ();
    wlt_out_if out_if ();

    worst_latency_tracker_core #(
        .ENTRIES(ENTRIES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // tracker state as the testbench sees it
    t_entry worst_tbl [ENTRIES];
    logic [TIME_W-1:0]  mark_time;
    logic [CAUSE_W-1:0] mark_cause;
    logic [FILE_W-1:0]  mark_file;
    logic [LINE_W-1:0]  mark_line;
    logic [ADDR_W-1:0]  mark_address;
    logic [TASK_W-1:0]  mark_task_id;
    logic [COUNT_W-1:0] end_samples;
    logic               logging_on;

    t_out_item expected_reads [$];
    int error_count;
    int idle_pct;
    int stall_pct;

    logic [FILE_W-1:0] point_file [POINTS];
    logic [LINE_W-1:0] point_line [POINTS];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_model_table();
        for (int i = 0; i < ENTRIES; i++) begin
            worst_tbl[i] = '0;
        end
        end_samples = '0;
    endfunction

    function automatic void track_item(input t_in_item it);
        logic              active;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] lowest;
        int                pick;
        t_entry            e;
        t_out_item         res;
        active = logging_on && it.outermost;
        case (t_func'(it.func))
            FN_START: begin
                if (active) begin
                    mark_time = it.timestamp;
                    if (it.cause_code == CAUSE_IRQ_ALIAS) begin
                        mark_cause = CAUSE_IRQ;
                    end else if (it.cause_code == CAUSE_RESERVED) begin
                        mark_cause = CAUSE_UNKNOWN;
                    end else begin
                        mark_cause = it.cause_code;
                    end
                    mark_file    = it.file_id;
                    mark_line    = it.line;
                    mark_address = it.code_address;
                    mark_task_id = it.task_id;
                end
            end
            FN_END: begin
                if (active) begin
                    span = it.timestamp - mark_time;
                    lowest = '1;
                    pick = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (lowest > worst_tbl[i].latency) begin
                            lowest = worst_tbl[i].latency;
                            pick = i;
                        end
                        if (worst_tbl[i].to_line == it.line && worst_tbl[i].to_file == it.file_id) begin
                            pick = i;
                            break;
                        end
                    end
                    if (span > worst_tbl[pick].latency) begin
                        worst_tbl[pick] = '{span, mark_cause, mark_file, mark_line, mark_address,
                                            mark_task_id, it.file_id, it.line, it.code_address,
                                            it.task_id};
                    end
                    end_samples++;
                end
            end
            FN_CLEAR: begin
                clear_model_table();
            end
            FN_READ: begin
                e = '0;
                if (it.entry_index < ENTRIES) begin
                    e = worst_tbl[it.entry_index];
                end
                res = '{e.latency, e.cause, e.from_file, e.from_line, e.from_address, e.from_task,
                        e.to_file, e.to_line, e.to_address, e.to_task, end_samples};
                expected_reads.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    function automatic void compare_read(input t_out_item exp_r, input t_out_item act_r);
        check_field("entry_latency", exp_r.entry_latency, act_r.entry_latency);
        check_field("entry_cause", 32'(exp_r.entry_cause), 32'(act_r.entry_cause));
        check_field("begin_file", 32'(exp_r.begin_file), 32'(act_r.begin_file));
        check_field("begin_line", 32'(exp_r.begin_line), 32'(act_r.begin_line));
        check_field("begin_address", exp_r.begin_address, act_r.begin_address);
        check_field("begin_task", 32'(exp_r.begin_task), 32'(act_r.begin_task));
        check_field("finish_file", 32'(exp_r.finish_file), 32'(act_r.finish_file));
        check_field("finish_line", 32'(exp_r.finish_line), 32'(act_r.finish_line));
        check_field("finish_address", exp_r.finish_address, act_r.finish_address);
        check_field("finish_task", 32'(exp_r.finish_task), 32'(act_r.finish_task));
        check_field("sample_count", exp_r.sample_count, act_r.sample_count);
    endfunction

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_reads.size() == 0) begin
                $error("read result transfer with nothing expected");
                error_count++;
            end else begin
                compare_read(expected_reads.pop_front(), out_if.data);
            end
        end
    end

    function automatic t_in_item make_item(input t_func fn, input logic [FILE_W-1:0] file,
                                           input logic [LINE_W-1:0] ln,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [TASK_W-1:0] tid,
                                           input logic [TIME_W-1:0] ts,
                                           input logic [CAUSE_W-1:0] cause, input logic outer,
                                           input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.func         = fn;
        it.file_id      = file;
        it.line         = ln;
        it.code_address = addr;
        it.task_id      = tid;
        it.timestamp    = ts;
        it.cause_code   = cause;
        it.outermost    = outer;
        it.entry_index  = idx;
        return it;
    endfunction

    function automatic t_in_item read_item(input logic [IDX_W-1:0] idx);
        return make_item(FN_READ, FILE_W'($urandom), LINE_W'($urandom), $urandom,
                         TASK_W'($urandom), $urandom, CAUSE_W'($urandom), 1'($urandom), idx);
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        track_item(it);
    endtask

    // stop sending until every read result is back and the block has gone quiet
    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_logging(input logic en);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        logging_on = en;
    endtask

    function automatic logic [TIME_W-1:0] pick_span();
        case ($urandom_range(39))
            0: return $urandom;
            1: return 32'hffff_ffff - $urandom_range(3);
            default: return $urandom_range(20000);
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(read_item(4'd0));
        send_item(read_item(IDX_W'(ENTRIES - 1)));
    endtask

    task automatic test_gated_events();
        send_item(make_item(FN_START, 16'h0001, 16'h0001, 32'h100, 15'h1, 32'd100, 3'd1, 1'b1,
                            4'd0));
        send_item(make_item(FN_END, 16'h0001, 16'h0001, 32'h200, 15'h1, 32'd500, 3'd1, 1'b1,
                            4'd0));
        send_item(read_item(4'd0));
        set_logging(1'b1);
        send_item(make_item(FN_START, 16'h0002, 16'h0002, 32'h100, 15'h2, 32'd100, 3'd3, 1'b0,
                            4'd0));
        send_item(make_item(FN_END, 16'h0002, 16'h0002, 32'h200, 15'h2, 32'd900, 3'd3, 1'b0,
                            4'd0));
        send_item(read_item(4'd0));
    endtask

    task automatic test_cause_mapping();
        // irq alias, then an end point of file 0 line 0 that hits a cleared entry
        send_item(make_item(FN_START, 16'h1234, 16'h0042, 32'h0, 15'h0, 32'd1000,
                            CAUSE_IRQ_ALIAS, 1'b1, 4'd0));
        send_item(make_item(FN_END, 16'h0000, 16'h0000, 32'h0, 15'h0, 32'd1500, 3'd0, 1'b1,
                            4'd0));
        send_item(read_item(4'd0));
        send_item(make_item(FN_START, 16'hffff, 16'hffff, 32'hffff_ffff, 15'h7fff, 32'h0,
                            CAUSE_RESERVED, 1'b1, 4'hf));
        send_item(make_item(FN_END, 16'hffff, 16'hffff, 32'hffff_ffff, 15'h7fff, 32'hffff_ffff,
                            3'd7, 1'b1, 4'hf));
        send_item(read_item(4'd1));
    endtask

    task automatic test_wrap_and_ties();
        send_item(make_item(FN_START, 16'h0005, 16'h0006, 32'h55, 15'h5, 32'hffff_fff0, 3'd4,
                            1'b1, 4'd0));
        send_item(make_item(FN_END, 16'h0005, 16'h0005, 32'h66, 15'h6, 32'h0000_0010, 3'd0,
                            1'b1, 4'd0));
        send_item(read_item(4'd2));
        // same latency at the same end point must not replace the entry
        send_item(make_item(FN_START, 16'h0007, 16'h0007, 32'h77, 15'h7, 32'd0, 3'd0, 1'b1,
                            4'd0));
        send_item(make_item(FN_END, 16'h0000, 16'h0000, 32'h88, 15'h8, 32'd500, 3'd0, 1'b1,
                            4'd0));
        send_item(read_item(4'd0));
    endtask

    task automatic test_clear();
        send_item(make_item(FN_CLEAR, 16'h0, 16'h0, 32'h0, 15'h0, 32'h0, 3'd0, 1'b0, 4'd0));
        send_item(read_item(4'd0));
        // pending start point survives the clear
        send_item(make_item(FN_END, 16'h0009, 16'h0009, 32'h99, 15'h9, 32'd77, 3'd0, 1'b1,
                            4'd0));
        send_item(read_item(4'd0));
        send_item(read_item(4'd1));
    endtask

    task automatic run_traffic(input int n_items, input int idle, input int stall);
        int               sent;
        int               r;
        int               p;
        logic             outer;
        logic [TIME_W-1:0] t0;
        idle_pct  = idle;
        stall_pct = stall;
        for (int k = 0; k < POINTS; k++) begin
            point_file[k] = FILE_W'($urandom);
            point_line[k] = LINE_W'($urandom);
        end
        point_file[0] = '0;
        point_line[0] = '0;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 60) begin
                t0 = $urandom;
                p  = $urandom_range(POINTS - 1);
                send_item(make_item(FN_START, FILE_W'($urandom), LINE_W'($urandom), $urandom,
                                    TASK_W'($urandom), t0, CAUSE_W'($urandom), 1'b1,
                                    IDX_W'($urandom)));
                send_item(make_item(FN_END, point_file[p], point_line[p], $urandom,
                                    TASK_W'($urandom), t0 + pick_span(), CAUSE_W'($urandom),
                                    1'b1, IDX_W'($urandom)));
                sent += 2;
                if ($urandom_range(1)) begin
                    send_item(read_item(IDX_W'($urandom)));
                    sent++;
                end
            end else if (r < 80) begin
                send_item(read_item(IDX_W'($urandom)));
                sent++;
            end else if (r < 99) begin
                outer = 1'($urandom);
                case ($urandom_range(2))
                    0: send_item(make_item(FN_START, FILE_W'($urandom), LINE_W'($urandom),
                                           $urandom, TASK_W'($urandom), $urandom,
                                           CAUSE_W'($urandom), outer, IDX_W'($urandom)));
                    1: send_item(make_item(FN_END, FILE_W'($urandom), LINE_W'($urandom),
                                           $urandom, TASK_W'($urandom), $urandom,
                                           CAUSE_W'($urandom), outer, IDX_W'($urandom)));
                    default: send_item(read_item(IDX_W'($urandom)));
                endcase
                sent++;
            end else begin
                send_item(make_item(FN_CLEAR, FILE_W'($urandom), LINE_W'($urandom), $urandom,
                                    TASK_W'($urandom), $urandom, CAUSE_W'($urandom),
                                    1'($urandom), IDX_W'($urandom)));
                sent++;
            end
            if ($urandom_range(49) == 0) begin
                drain();
            end
        end
        drain();
    endtask

    task automatic test_random_traffic();
        set_logging(1'b1);
        run_traffic(425, 0, 0);
        set_logging(1'b0);
        run_traffic(40, 55, 0);
        set_logging(1'b1);
        run_traffic(385, 55, 0);
        run_traffic(425, 0, 55);
        run_traffic(425, 32, 32);
    endtask

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        i_rst_n      = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        error_count  = 0;
        logging_on   = 1'b0;
        mark_time    = '0;
        mark_cause   = '0;
        mark_file    = '0;
        mark_line    = '0;
        mark_address = '0;
        mark_task_id = '0;
        clear_model_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_gated_events();
        test_cause_mapping();
        test_wrap_and_ties();
        test_clear();
        test_random_traffic();

        drain();
        if (error_count == 0 && expected_reads.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
